[hw/rtl/kvs_pkg.sv]
`timescale 1ns / 1ps

package kvs_pkg;

	// Sizing of the entry table and the value buffer.
	localparam int MAX_ENTRIES  = 16;
	localparam int BUFFER_BYTES = 64;
	localparam int IDX_W        = $clog2(MAX_ENTRIES);
	localparam int CNT_W        = $clog2(MAX_ENTRIES + 1);
	localparam int ADDR_W       = $clog2(BUFFER_BYTES);
	localparam int USED_W       = $clog2(BUFFER_BYTES + 1);
	localparam int CFG_W        = 7;

	// Operation codes.
	localparam logic [1:0] OP_DEFINE = 2'd0;
	localparam logic [1:0] OP_WRITE  = 2'd1;
	localparam logic [1:0] OP_READ   = 2'd2;

	// Status codes.
	localparam logic [2:0] ST_OK            = 3'd0;
	localparam logic [2:0] ST_NOT_FOUND     = 3'd1;
	localparam logic [2:0] ST_TYPE_MISMATCH = 3'd2;
	localparam logic [2:0] ST_ORDER         = 3'd3;
	localparam logic [2:0] ST_NO_SPACE      = 3'd4;

	// Data type codes.
	localparam logic [3:0] DT_BOOL   = 4'd0;
	localparam logic [3:0] DT_U8     = 4'd1;
	localparam logic [3:0] DT_U16    = 4'd2;
	localparam logic [3:0] DT_U32    = 4'd3;
	localparam logic [3:0] DT_I8     = 4'd4;
	localparam logic [3:0] DT_I16    = 4'd5;
	localparam logic [3:0] DT_I32    = 4'd6;
	localparam logic [3:0] DT_FLOAT  = 4'd7;
	localparam logic [3:0] DT_DOUBLE = 4'd8;

	typedef struct packed {
		logic [1:0]  operation;
		logic [31:0] key;
		logic [3:0]  data_type;
		logic [63:0] write_value;
	} kvs_cmd_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [63:0] read_value;
		logic        changed;
	} kvs_rsp_t;

	// One row of the entry table.
	typedef struct packed {
		logic [31:0]       key;
		logic [3:0]        data_type;
		logic [USED_W-1:0] offset;
	} kvs_entry_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_SEARCH,
		S_COMPARE,
		S_BYTE,
		S_CAPTURE
	} kvs_state_t;

	// Byte size of a data type; unsupported types take no bytes.
	function automatic logic [3:0] kvs_type_size(input logic [3:0] dtype);
		logic [3:0] sz;
		case (dtype)
			DT_BOOL, DT_U8, DT_I8:      sz = 4'd1;
			DT_U16, DT_I16:             sz = 4'd2;
			DT_U32, DT_I32, DT_FLOAT:   sz = 4'd4;
			DT_DOUBLE:                  sz = 4'd8;
			default:                    sz = 4'd0;
		endcase
		return sz;
	endfunction

endpackage

[hw/rtl/typed_key_value_store_core.sv]
`timescale 1ns / 1ps

// Typed key-value store. Give one command with start while busy is low; the
// result appears on result for exactly one cycle with done high and cannot
// be held off, so the receiver must take it then. A define is checked and
// entered in the execute state. A write or read runs S binary-search probes
// (at most log2(entries)+1, 5 for 16 entries), each a read and a compare of
// the entry table memory, then walks the value bytes through the single-byte
// value memory port: a write stores one byte in each byte state, and a read
// addresses a byte in the byte state and takes it in the capture state. A
// missing key ends after the last probe. The buffer size register (cfg_data)
// is taken at any cycle and must only be written while the block is idle.
module typed_key_value_store_core (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	output logic                      busy,
	input  kvs_pkg::kvs_cmd_t         cmd,
	output logic                      done,
	output kvs_pkg::kvs_rsp_t         result,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [kvs_pkg::CFG_W-1:0] cfg_data
);
	import kvs_pkg::*;

	kvs_state_t        state_q, state_d;

	// Control state.
	logic [CNT_W-1:0]  count_q;
	logic [USED_W-1:0] used_q;
	logic [CFG_W-1:0]  cfg_q;
	logic              done_q;

	// Working registers of the current command.
	kvs_cmd_t          cmd_q;
	kvs_rsp_t          result_q;
	logic [31:0]       last_key_q;
	logic [CNT_W-1:0]  lo_q, hi_q, mid_q;
	logic [USED_W-1:0] off_q;
	logic [3:0]        i_q, sz_q;
	logic [63:0]       rval_q;

	// Memory ports.
	logic              ent_we;
	kvs_entry_t        ent_wdata, ent_rdata;
	logic [IDX_W-1:0]  ent_raddr;
	logic              val_we;
	logic [7:0]        val_wdata, val_rdata;
	logic [USED_W-1:0] byte_addr;

	// Combinational helpers.
	logic [CNT_W:0]    mid_sum;
	logic [CNT_W-1:0]  mid;
	logic [USED_W-1:0] limit, free_bytes, def_size;
	logic [2:0]        def_status;
	logic              def_ok;
	logic              is_write;
	logic              hit, key_less;
	logic              last_byte;
	logic              finish;
	logic [2:0]        fin_status;
	logic              fin_changed;
	logic              fin_rval;
	logic [63:0]       rval_nx;

	assign busy      = (state_q != S_IDLE);
	assign cfg_ready = 1'b1;
	assign done      = done_q;
	assign result    = result_q;
	assign is_write  = (cmd_q.operation == OP_WRITE);

	// Free space and define checks.
	always_comb begin
		limit = (USED_W'(cfg_q) > USED_W'(BUFFER_BYTES)) ? USED_W'(BUFFER_BYTES)
			: USED_W'(cfg_q);
		free_bytes = (limit > used_q) ? (limit - used_q) : '0;
		def_size   = USED_W'(kvs_type_size(cmd_q.data_type));
		if (count_q >= CNT_W'(MAX_ENTRIES)) begin
			def_status = ST_NO_SPACE;
		end else if ((count_q != '0) && (cmd_q.key <= last_key_q)) begin
			def_status = ST_ORDER;
		end else if (def_size > free_bytes) begin
			def_status = ST_NO_SPACE;
		end else begin
			def_status = ST_OK;
		end
		def_ok = (def_status == ST_OK);
	end

	// Search probe and byte addressing.
	assign mid_sum   = {1'b0, lo_q} + {1'b0, hi_q};
	assign mid       = mid_sum[CNT_W:1];
	assign ent_raddr = mid[IDX_W-1:0];
	assign hit       = (ent_rdata.key == cmd_q.key);
	assign key_less  = (cmd_q.key < ent_rdata.key);
	assign byte_addr = off_q + USED_W'(i_q);
	assign last_byte = ((i_q + 4'd1) == sz_q);
	assign val_wdata = cmd_q.write_value[{i_q[2:0], 3'b000} +: 8];

	assign ent_wdata.key       = cmd_q.key;
	assign ent_wdata.data_type = cmd_q.data_type;
	assign ent_wdata.offset    = used_q;

	// Read value with the byte that arrives in the capture cycle merged in.
	always_comb begin
		rval_nx = rval_q;
		if (state_q == S_CAPTURE) begin
			rval_nx[{i_q[2:0], 3'b000} +: 8] = val_rdata;
		end
	end

	// Next state and strobes.
	always_comb begin
		state_d     = state_q;
		finish      = 1'b0;
		fin_status  = ST_OK;
		fin_changed = 1'b0;
		fin_rval    = 1'b0;
		ent_we      = 1'b0;
		val_we      = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				if (cmd_q.operation == OP_DEFINE) begin
					finish     = 1'b1;
					fin_status = def_status;
					ent_we     = def_ok;
					state_d    = S_IDLE;
				end else if (cmd_q.operation == OP_WRITE || cmd_q.operation == OP_READ) begin
					state_d = S_SEARCH;
				end else begin
					finish  = 1'b1;
					state_d = S_IDLE;
				end
			end
			S_SEARCH: begin
				if (lo_q < hi_q) begin
					state_d = S_COMPARE;
				end else begin
					finish     = 1'b1;
					fin_status = ST_NOT_FOUND;
					state_d    = S_IDLE;
				end
			end
			S_COMPARE: begin
				if (!hit) begin
					state_d = S_SEARCH;
				end else if (ent_rdata.data_type != cmd_q.data_type) begin
					finish     = 1'b1;
					fin_status = ST_TYPE_MISMATCH;
					state_d    = S_IDLE;
				end else if (kvs_type_size(cmd_q.data_type) == 4'd0) begin
					finish      = 1'b1;
					fin_changed = is_write;
					fin_rval    = !is_write;
					state_d     = S_IDLE;
				end else begin
					state_d = S_BYTE;
				end
			end
			S_BYTE: begin
				if (byte_addr >= USED_W'(BUFFER_BYTES)) begin
					finish      = 1'b1;
					fin_changed = is_write;
					fin_rval    = !is_write;
					state_d     = S_IDLE;
				end else if (is_write) begin
					val_we = 1'b1;
					if (last_byte) begin
						finish      = 1'b1;
						fin_changed = 1'b1;
						state_d     = S_IDLE;
					end
				end else begin
					state_d = S_CAPTURE;
				end
			end
			S_CAPTURE: begin
				if (last_byte) begin
					finish   = 1'b1;
					fin_rval = 1'b1;
					state_d  = S_IDLE;
				end else begin
					state_d = S_BYTE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Table fill level, buffer use, size register and result strobe.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			used_q  <= '0;
			cfg_q   <= CFG_W'(BUFFER_BYTES);
			done_q  <= 1'b0;
		end else begin
			done_q <= finish;
			if (cfg_valid && cfg_ready) begin
				cfg_q <= cfg_data;
			end
			if (ent_we) begin
				count_q <= count_q + CNT_W'(1);
				used_q  <= used_q + def_size;
			end
		end
	end

	// Command, search bounds, byte walk and result payload.
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && start) begin
			cmd_q  <= cmd;
			rval_q <= '0;
		end
		if (ent_we) begin
			last_key_q <= cmd_q.key;
		end
		case (state_q)
			S_EXEC: begin
				lo_q <= '0;
				hi_q <= count_q;
			end
			S_SEARCH: begin
				mid_q <= mid;
			end
			S_COMPARE: begin
				if (hit) begin
					off_q <= ent_rdata.offset;
					sz_q  <= kvs_type_size(cmd_q.data_type);
					i_q   <= 4'd0;
				end else if (key_less) begin
					hi_q <= mid_q;
				end else begin
					lo_q <= mid_q + CNT_W'(1);
				end
			end
			S_BYTE: begin
				if (val_we) begin
					i_q <= i_q + 4'd1;
				end
			end
			S_CAPTURE: begin
				rval_q <= rval_nx;
				i_q    <= i_q + 4'd1;
			end
			default: begin
			end
		endcase
		if (finish) begin
			result_q.status     <= fin_status;
			result_q.read_value <= fin_rval ? rval_nx : 64'd0;
			result_q.changed    <= fin_changed;
		end
	end

	kvs_entry_ram u_entry_ram (
		.clk   (clk),
		.we    (ent_we),
		.waddr (count_q[IDX_W-1:0]),
		.wdata (ent_wdata),
		.raddr (ent_raddr),
		.rdata (ent_rdata)
	);

	kvs_value_ram u_value_ram (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (val_we),
		.waddr  (byte_addr[ADDR_W-1:0]),
		.wdata  (val_wdata),
		.raddr  (byte_addr[ADDR_W-1:0]),
		.rdata  (val_rdata)
	);

endmodule

[hw/rtl/kvs_entry_ram.sv]
`timescale 1ns / 1ps

// Entry table: key, type and byte offset per entry, one write and one
// registered read port.
module kvs_entry_ram (
	input  logic                      clk,
	input  logic                      we,
	input  logic [kvs_pkg::IDX_W-1:0] waddr,
	input  kvs_pkg::kvs_entry_t       wdata,
	input  logic [kvs_pkg::IDX_W-1:0] raddr,
	output kvs_pkg::kvs_entry_t       rdata
);
	import kvs_pkg::*;

	kvs_entry_t mem [MAX_ENTRIES];
	kvs_entry_t rdata_s1;

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		rdata_s1 <= mem[raddr];
	end

	assign rdata = rdata_s1;

endmodule

[hw/rtl/kvs_value_ram.sv]
`timescale 1ns / 1ps

// Value buffer, one byte per word. A valid bit per byte makes every byte
// read as zero until it is first written after reset.
module kvs_value_ram (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       we,
	input  logic [kvs_pkg::ADDR_W-1:0] waddr,
	input  logic [7:0]                 wdata,
	input  logic [kvs_pkg::ADDR_W-1:0] raddr,
	output logic [7:0]                 rdata
);
	import kvs_pkg::*;

	logic [7:0]              mem [BUFFER_BYTES];
	logic [BUFFER_BYTES-1:0] vld_q;
	logic [7:0]              rdata_s1;
	logic                    rvld_s1;

	// Byte storage.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_s1 <= mem[raddr];
	end

	// Written marks, cleared at reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q   <= '0;
			rvld_s1 <= 1'b0;
		end else begin
			if (we) begin
				vld_q[waddr] <= 1'b1;
			end
			rvld_s1 <= vld_q[raddr];
		end
	end

	assign rdata = rvld_s1 ? rdata_s1 : 8'd0;

endmodule
